[rtl/core/wls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_pkg: shared types and constants for the windowed latency statistics block
// Holds the ring depth, derived widths, the request and result structs and the
// command codes used by the sorter cells, the divider and the top level.
// ----------------------------------------------------------------------------
package wls_pkg;

	// Ring depth and widths derived from it.
	localparam int DEPTH = 128;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SUM_W = 36;
	localparam int ACC_W = 32 + AW;
	localparam int DIV_W = (SUM_W > ACC_W) ? SUM_W : ACC_W;
	localparam int VW    = (CW > 4) ? CW : 4;
	localparam int PW    = $clog2(DEPTH * 100 + 1) + 1;
	localparam int XW    = ((CW > 7) ? CW : 7) + 1;

	// Command codes.
	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_REPORT  = 2'd1,
		CMD_HISTORY = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] duration;
		logic [6:0]  position;
	} request_t;

	typedef struct packed {
		logic [31:0] min_value;
		logic [31:0] avg_value;
		logic [31:0] p50_value;
		logic [31:0] p95_value;
		logic [31:0] p99_value;
		logic [31:0] max_value;
		logic [7:0]  sample_count;
		logic [31:0] history_sample;
		logic        history_valid;
	} result_t;

	// Control shared by every sorter cell.
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctl_t;

endpackage
`default_nettype wire

[rtl/core/wls_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_cell: one cell of the systolic insertion sorter
// Keeps the smaller of its stored value and the incoming value and hands the
// larger one to its right neighbor. In shift mode it takes the stored value
// of its right neighbor, so the sorted row drains out of the first cell.
// ----------------------------------------------------------------------------
module wls_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire wls_pkg::cell_ctl_t ctl,
	input  wire                  in_valid,
	input  wire  [31:0]          in_data,
	input  wire                  nb_valid,
	input  wire  [31:0]          nb_data,
	output logic                 out_valid,
	output logic [31:0]          out_data,
	output logic                 val_valid,
	output logic [31:0]          val_data
);
	import wls_pkg::*;

	logic        valid_q;
	logic [31:0] data_q;
	logic        pass_valid_q;
	logic [31:0] pass_data_q;

	// Control flags of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q      <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q      <= nb_valid;
			pass_valid_q <= 1'b0;
		end else if (in_valid) begin
			valid_q      <= 1'b1;
			pass_valid_q <= valid_q;
		end else begin
			pass_valid_q <= 1'b0;
		end
	end

	// Stored value and the value handed on.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= nb_data;
		end else if (in_valid) begin
			if (!valid_q) begin
				data_q <= in_data;
			end else if (in_data < data_q) begin
				data_q      <= in_data;
				pass_data_q <= data_q;
			end else begin
				pass_data_q <= in_data;
			end
		end
	end

	assign out_valid = pass_valid_q;
	assign out_data  = pass_data_q;
	assign val_valid = valid_q;
	assign val_data  = data_q;

endmodule
`default_nettype wire

[rtl/core/wls_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_div: iterative restoring divider
// Produces one quotient bit per cycle and pulses done with the quotient once
// every quotient bit is formed. Shared by the window average and the ring average.
// ----------------------------------------------------------------------------
module wls_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [wls_pkg::DIV_W-1:0]    dividend,
	input  wire  [wls_pkg::VW-1:0]       divisor,
	output logic                         done,
	output logic [wls_pkg::DIV_W-1:0]    quotient
);
	import wls_pkg::*;

	localparam int NW = $clog2(DIV_W);

	logic          run_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [DIV_W-1:0] quo_q;

	logic [VW:0]   rem_sh;
	logic [VW:0]   div_ext;
	logic          ge;
	logic [VW:0]   rem_nx;

	// One trial subtraction per cycle.
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		div_ext = {1'b0, div_q};
		ge      = (rem_sh >= div_ext);
		rem_nx  = ge ? (rem_sh - div_ext) : rem_sh;
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_nx[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[rtl/core/windowed_latency_statistics_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_latency_statistics_top: windowed latency statistics monitor
// Averages pushed durations over windows, keeps the averages in a ring and
// reports minimum, mean, maximum and percentiles of the ring, or reads back one ring entry.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Push and
// clear give no result; report and history read give one result, shown on
// result for exactly one cycle while done is high. The receiver cannot stall.
// window_frames is written through cfg_valid/cfg_data; cfg_ready is always
// high. Writes must be made while the block is idle; the block does not enforce it.
// Steps per request:
//   push that does not close a window: the window sum and fill are updated.
//   push that closes a window: the iterative divider forms the window mean.
//   clear: empties the window and the ring.  history read: registered ring read.
//   report with n samples: the ring is
//   read one entry a cycle into the sorter cell row, the row settles,
//   drains one value a cycle, then the divider forms the mean.
//   report on an empty ring: a zeroed result with a sample count of zero.
// Reset empties the window and the ring and sets window_frames to 6; the ring
// memory itself is not cleared, entries are read only after they are written.
// ----------------------------------------------------------------------------
module windowed_latency_statistics_top (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire wls_pkg::request_t request,
	output logic               done,
	output wls_pkg::result_t   result,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [3:0]         cfg_data
);
	import wls_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_DIV,
		ST_HIST_RD,
		ST_HIST_OUT,
		ST_LOAD,
		ST_SETTLE,
		ST_UNLOAD,
		ST_AVG_DIV
	} state_t;

	state_t state_q;

	logic [3:0]       wf_q;
	logic [SUM_W-1:0] sum_q;
	logic [3:0]       fill_q;
	logic [AW-1:0]    wp_q;
	logic             full_q;

	logic [AW-1:0]    rd_addr_q;
	logic [31:0]      rd_data_q;
	logic [31:0]      mem [0:DEPTH-1];

	logic [CW-1:0]    ld_cnt_q;
	logic             iss_s1;
	logic             iss_s2;
	logic [ACC_W-1:0] acc_q;
	logic [CW-1:0]    wait_q;
	logic [CW-1:0]    j_q;
	logic [PW-1:0]    c100_q;

	result_t          result_q;
	logic             done_q;

	// Accept and derived counts.
	logic             accept;
	logic [CW-1:0]    n;
	logic [SUM_W-1:0] new_sum;
	logic [3:0]       new_fill;
	logic             close;
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    rot;
	logic             pos_ok;
	logic [AW-1:0]    hist_idx;
	logic [PW-1:0]    n_w;
	logic [PW-1:0]    n50;
	logic [PW-1:0]    n95;
	logic [PW-1:0]    n99;
	logic [PW-1:0]    c100_next;
	logic             last_j;

	always_comb begin
		accept    = start && (state_q == ST_IDLE);
		n         = full_q ? CW'(DEPTH) : CW'(wp_q);
		new_sum   = sum_q + SUM_W'(request.duration);
		new_fill  = fill_q + 4'd1;
		close     = (new_fill >= wf_q) && (new_fill != 4'd0);
		pos_x     = XW'(request.position);
		rot       = XW'(wp_q) + pos_x;
		if (rot >= XW'(DEPTH)) begin
			rot = rot - XW'(DEPTH);
		end
		pos_ok    = (pos_x < XW'(n));
		hist_idx  = full_q ? rot[AW-1:0] : pos_x[AW-1:0];
		n_w       = PW'(n);
		n50       = n_w * PW'(50);
		n95       = n_w * PW'(95);
		n99       = n_w * PW'(99);
		c100_next = c100_q + PW'(100);
		last_j    = ((j_q + CW'(1)) == n);
	end

	// Sorter cell row.
	cell_ctl_t   cell_ctl;
	logic        pv [0:DEPTH];
	logic [31:0] pd [0:DEPTH];
	logic        sv [0:DEPTH];
	logic [31:0] sd [0:DEPTH];

	always_comb begin
		cell_ctl.clear = accept && (request.command == CMD_REPORT);
		cell_ctl.shift = (state_q == ST_UNLOAD);
	end

	assign pv[0]     = iss_s2;
	assign pd[0]     = rd_data_q;
	assign sv[DEPTH] = 1'b0;
	assign sd[DEPTH] = '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		wls_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.in_valid  (pv[g]),
			.in_data   (pd[g]),
			.nb_valid  (sv[g+1]),
			.nb_data   (sd[g+1]),
			.out_valid (pv[g+1]),
			.out_data  (pd[g+1]),
			.val_valid (sv[g]),
			.val_data  (sd[g])
		);
	end

	// Shared divider.
	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [VW-1:0]    div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(acc_q);
		div_divisor  = VW'(n);
		if (accept && (request.command == CMD_PUSH) && close) begin
			div_start    = 1'b1;
			div_dividend = DIV_W'(new_sum);
			div_divisor  = VW'(new_fill);
		end else if ((state_q == ST_UNLOAD) && last_j) begin
			div_start = 1'b1;
		end
	end

	wls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Ring memory with registered read.
	always_ff @(posedge clk) begin
		if ((state_q == ST_PUSH_DIV) && div_done) begin
			mem[wp_q] <= div_quot[31:0];
		end
		rd_data_q <= mem[rd_addr_q];
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q <= 4'd6;
		end else if (cfg_valid) begin
			wf_q <= cfg_data;
		end
	end

	// Sequencer with window state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			fill_q    <= '0;
			wp_q      <= '0;
			full_q    <= 1'b0;
			rd_addr_q <= '0;
			ld_cnt_q  <= '0;
			iss_s1    <= 1'b0;
			iss_s2    <= 1'b0;
			acc_q     <= '0;
			wait_q    <= '0;
			j_q       <= '0;
			c100_q    <= '0;
			result_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			iss_s2 <= iss_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (request.command)
							CMD_PUSH: begin
								if (close) begin
									sum_q   <= '0;
									fill_q  <= '0;
									state_q <= ST_PUSH_DIV;
								end else begin
									sum_q  <= new_sum;
									fill_q <= new_fill;
								end
							end
							CMD_CLEAR: begin
								sum_q  <= '0;
								fill_q <= '0;
								wp_q   <= '0;
								full_q <= 1'b0;
							end
							CMD_REPORT: begin
								result_q              <= '0;
								result_q.sample_count <= 8'(n);
								if (n == '0) begin
									done_q <= 1'b1;
								end else begin
									ld_cnt_q <= '0;
									acc_q    <= '0;
									state_q  <= ST_LOAD;
								end
							end
							CMD_HISTORY: begin
								result_q              <= '0;
								result_q.sample_count <= 8'(n);
								if (pos_ok) begin
									rd_addr_q <= hist_idx;
									state_q   <= ST_HIST_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PUSH_DIV: begin
					if (div_done) begin
						if (wp_q == AW'(DEPTH - 1)) begin
							wp_q   <= '0;
							full_q <= 1'b1;
						end else begin
							wp_q <= wp_q + AW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_HIST_RD: begin
					state_q <= ST_HIST_OUT;
				end
				ST_HIST_OUT: begin
					result_q.history_sample <= rd_data_q;
					result_q.history_valid  <= 1'b1;
					done_q                  <= 1'b1;
					state_q                 <= ST_IDLE;
				end
				ST_LOAD: begin
					if (iss_s2) begin
						acc_q <= acc_q + ACC_W'(rd_data_q);
					end
					if (ld_cnt_q != n) begin
						rd_addr_q <= ld_cnt_q[AW-1:0];
						ld_cnt_q  <= ld_cnt_q + CW'(1);
						iss_s1    <= 1'b1;
					end else begin
						iss_s1 <= 1'b0;
						if (!iss_s1 && !iss_s2) begin
							wait_q  <= '0;
							state_q <= ST_SETTLE;
						end
					end
				end
				ST_SETTLE: begin
					wait_q <= wait_q + CW'(1);
					if (wait_q == CW'(DEPTH)) begin
						j_q     <= '0;
						c100_q  <= '0;
						state_q <= ST_UNLOAD;
					end
				end
				ST_UNLOAD: begin
					if (j_q == '0) begin
						result_q.min_value <= sd[0];
					end
					if ((c100_q <= n50) && (c100_next > n50)) begin
						result_q.p50_value <= sd[0];
					end
					if ((c100_q <= n95) && (c100_next > n95)) begin
						result_q.p95_value <= sd[0];
					end
					if ((c100_q <= n99) && (c100_next > n99)) begin
						result_q.p99_value <= sd[0];
					end
					j_q    <= j_q + CW'(1);
					c100_q <= c100_next;
					if (last_j) begin
						result_q.max_value <= sd[0];
						state_q            <= ST_AVG_DIV;
					end
				end
				ST_AVG_DIV: begin
					if (div_done) begin
						result_q.avg_value <= div_quot[31:0];
						done_q             <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the windowed latency statistics block
// Drives pushes, reports, history reads and clears with random idle bursts,
// predicts every report and history result from its own copy of the window and
// ring state, and compares each result field by field in request order.
// ----------------------------------------------------------------------------
module testbench;
	import wls_pkg::*;

	localparam int RING = 128;
	localparam longint CYCLE_LIMIT = 3000000;

	// Predicted results, oldest first, checked against strobed results.
	class stats_scoreboard;
		result_t pending[$];
		logic [31:0] ring[RING];
		logic [35:0] win_sum;
		logic [3:0] win_fill;
		logic [3:0] frames;
		int wr_ptr;
		bit full;
		int mismatches;

		function void clear_state();
			win_sum = '0;
			win_fill = '0;
			wr_ptr = 0;
			full = 0;
		endfunction

		function int stored_count();
			return full ? RING : wr_ptr;
		endfunction

		// Note an accepted request and queue the result it will cause.
		function void note_request(request_t req);
			result_t res;
			logic [31:0] sorted[$];
			logic [39:0] total;
			logic [31:0] low;
			int n;
			n = stored_count();
			res = '0;
			res.sample_count = n[7:0];
			case (req.command)
				CMD_PUSH: begin
					win_sum = win_sum + {4'b0, req.duration};
					win_fill = win_fill + 4'd1;
					if (win_fill != 0 && win_fill >= frames) begin
						ring[wr_ptr] = 32'(win_sum / {32'b0, win_fill});
						wr_ptr = (wr_ptr + 1) % RING;
						if (wr_ptr == 0)
							full = 1;
						win_sum = '0;
						win_fill = '0;
					end
				end
				CMD_CLEAR: clear_state();
				CMD_REPORT: begin
					if (n > 0) begin
						total = '0;
						low = ring[0];
						for (int i = 0; i < n; i++) begin
							total += ring[i];
							if (ring[i] < low)
								low = ring[i];
							sorted = {sorted, ring[i]};
						end
						sorted.sort();
						res.min_value = low;
						res.avg_value = 32'(total / n);
						res.p50_value = sorted[(n * 50) / 100];
						res.p95_value = sorted[(n * 95) / 100];
						res.p99_value = sorted[(n * 99) / 100];
						res.max_value = sorted[n - 1];
					end
					pending = {pending, res};
				end
				default: begin
					if (req.position < n) begin
						res.history_sample = ring[full ? (wr_ptr + req.position) % RING
							: req.position];
						res.history_valid = 1'b1;
					end
					pending = {pending, res};
				end
			endcase
		endfunction

		function void report(string what, logic [39:0] got, logic [39:0] want);
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			mismatches++;
		endfunction

		// Compare one strobed result with the oldest prediction.
		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 0, 0);
				return;
			end
			want = pending.pop_front();
			if (got.min_value !== want.min_value) report("min", got.min_value, want.min_value);
			if (got.avg_value !== want.avg_value) report("avg", got.avg_value, want.avg_value);
			if (got.p50_value !== want.p50_value) report("p50", got.p50_value, want.p50_value);
			if (got.p95_value !== want.p95_value) report("p95", got.p95_value, want.p95_value);
			if (got.p99_value !== want.p99_value) report("p99", got.p99_value, want.p99_value);
			if (got.max_value !== want.max_value) report("max", got.max_value, want.max_value);
			if (got.sample_count !== want.sample_count)
				report("count", got.sample_count, want.sample_count);
			if (got.history_sample !== want.history_sample)
				report("history", got.history_sample, want.history_sample);
			if (got.history_valid !== want.history_valid)
				report("valid", got.history_valid, want.history_valid);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	request_t request = '0;
	logic done;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [3:0] cfg_data = '0;

	stats_scoreboard stats = new();
	longint cycles = 0;
	bit calm = 0;

	windowed_latency_statistics_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Check results and watch the cycle limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			stats.check_result(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Send one request and hold it until the block takes it. Start stays high
	// afterward so that requests can follow back to back; idling drops it.
	task automatic send(cmd_t cmd, logic [31:0] dur, logic [6:0] pos);
		request_t req;
		req.command = cmd;
		req.duration = dur;
		req.position = pos;
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		stats.note_request(req);
	endtask

	// Wait for every result and for a trailing window close to finish.
	task automatic drain();
		start <= 1'b0;
		while (stats.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_frames(logic [3:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		stats.frames = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_duration();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'h0;
			1: return $urandom_range(0, 32'h000F_FFFF);
			default: return $urandom();
		endcase
	endfunction

	// Random mix weighted toward pushes so the ring fills and wraps.
	task automatic random_phase(int count);
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 75)
				send(CMD_PUSH, random_duration(), 7'($urandom()));
			else if (roll < 83)
				send(CMD_REPORT, $urandom(), 7'($urandom()));
			else if (roll < 99)
				send(CMD_HISTORY, $urandom(), 7'($urandom()));
			else
				send(CMD_CLEAR, $urandom(), 7'($urandom()));
		end
	endtask

	initial begin
		stats.clear_state();
		stats.frames = 4'd6;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty ring, extremes, reset window size and clear.
		send(CMD_REPORT, 32'h0, 7'h0);
		send(CMD_HISTORY, 32'h0, 7'h7F);
		repeat (6) send(CMD_PUSH, 32'hFFFF_FFFF, 7'h7F);
		repeat (6) send(CMD_PUSH, 32'h0, 7'h0);
		send(CMD_REPORT, 32'hFFFF_FFFF, 7'h0);
		send(CMD_HISTORY, 32'h0, 7'h0);
		send(CMD_HISTORY, 32'h0, 7'h1);
		send(CMD_HISTORY, 32'h0, 7'h2);
		send(CMD_CLEAR, 32'h0, 7'h0);
		send(CMD_REPORT, 32'h0, 7'h0);

		// Zero acts as a window of one; lowering mid-window closes it.
		write_frames(4'd0);
		send(CMD_PUSH, 32'h1234_5678, 7'h0);
		write_frames(4'd15);
		repeat (3) send(CMD_PUSH, 32'hFFFF_FFFF, 7'h0);
		write_frames(4'd2);
		send(CMD_PUSH, 32'h1, 7'h0);
		send(CMD_REPORT, 32'h0, 7'h0);

		// Random phases over several window sizes; size one wraps the ring.
		write_frames(4'd1);
		random_phase(250);
		write_frames(4'd15);
		random_phase(100);
		write_frames(4'($urandom_range(2, 8)));
		random_phase(150);
		write_frames(4'd1);
		calm = 1;
		random_phase(200);
		drain();
		if (stats.mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
